// File: rtl/core/tata_pkg.sv
package tata_pkg;

  // Field and internal widths
  localparam int FORCE_W = 24;
  localparam int ANGLE_W = 16;
  localparam int ANG_W   = 18;
  localparam int CX_W    = 34;
  localparam int CZ_W    = 30;
  localparam int FMAX_W  = 28;
  localparam int DIV_W   = 40;
  localparam int STEP_W  = 5;
  localparam int CNT_W   = 6;
  localparam int PROD_W  = 61;
  localparam int CFG_IDX_W = 3;

  // Fixed-point constants
  localparam logic signed [ANG_W-1:0] PI_Q13      = 18'sd25736;
  localparam logic signed [CZ_W-1:0]  PI_Q24      = 30'sd52707179;
  localparam logic signed [CZ_W-1:0]  HALF_PI_Q24 = 30'sd26353589;
  localparam logic [29:0]             INV_GAIN_Q30 = 30'd652032874;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWAY_COEF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_COEF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRUST_UPPER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRUST_LOWER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_UPPER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOWER  = 3'd5;

  typedef struct packed {
    logic signed [FORCE_W-1:0] sway_coef;
    logic signed [FORCE_W-1:0] yaw_coef;
    logic signed [FORCE_W-1:0] thrust_upper;
    logic signed [FORCE_W-1:0] thrust_lower;
    logic signed [ANGLE_W-1:0] angle_upper;
    logic signed [ANGLE_W-1:0] angle_lower;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_SPLIT,
    OP_POL_INIT,
    OP_VEC_STEP,
    OP_POL_MUL,
    OP_POL_DONE,
    OP_FWD_INIT,
    OP_ROT_STEP,
    OP_FWD_DONE,
    OP_RAT_START,
    OP_DIV_STEP,
    OP_RAT_DONE,
    OP_SCL_START,
    OP_SCL_DONE,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic              sel;   // thruster: 0 port, 1 starboard
    logic              comp;  // force component: 0 x, 1 y
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic sat;
    logic fmax_zero;
    logic ratio_zero;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPLIT,
    ST_POL_INIT,
    ST_POL_ITER,
    ST_POL_MUL,
    ST_POL_DONE,
    ST_CHECK,
    ST_FWD_INIT,
    ST_FWD_ITER,
    ST_FWD_DONE,
    ST_RAT_START,
    ST_RAT_ITER,
    ST_RAT_DONE,
    ST_SCL_CHECK,
    ST_SCL_START,
    ST_SCL_ITER,
    ST_SCL_DONE,
    ST_FINISH
  } ctrl_state_t;

  // Saturate to the 24-bit force range
  function automatic logic signed [FORCE_W-1:0] sat24(input logic signed [47:0] v);
    logic signed [FORCE_W-1:0] r;
    if (v > 48'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -48'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[FORCE_W-1:0];
    end
    return r;
  endfunction

  // atan(2^-i) in Q24 radians
  function automatic logic signed [CZ_W-1:0] atan_q24(input logic [STEP_W-1:0] i);
    logic signed [CZ_W-1:0] r;
    unique case (i)
      5'd0:  r = 30'sd13176795;
      5'd1:  r = 30'sd7778716;
      5'd2:  r = 30'sd4110060;
      5'd3:  r = 30'sd2086331;
      5'd4:  r = 30'sd1047214;
      5'd5:  r = 30'sd524117;
      5'd6:  r = 30'sd262123;
      5'd7:  r = 30'sd131069;
      5'd8:  r = 30'sd65536;
      5'd9:  r = 30'sd32768;
      5'd10: r = 30'sd16384;
      5'd11: r = 30'sd8192;
      5'd12: r = 30'sd4096;
      5'd13: r = 30'sd2048;
      5'd14: r = 30'sd1024;
      5'd15: r = 30'sd512;
      5'd16: r = 30'sd256;
      5'd17: r = 30'sd128;
      5'd18: r = 30'sd64;
      5'd19: r = 30'sd32;
      5'd20: r = 30'sd16;
      5'd21: r = 30'sd8;
      5'd22: r = 30'sd4;
      5'd23: r = 30'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/tata_cfg.sv
module tata_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tata_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tata_pkg::FORCE_W-1:0]       cfg_data,
  output tata_pkg::cfg_t                     cfg
);

  tata_pkg::cfg_t cfg_r;

  // Write one register per request; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sway_coef    <= 24'sd0;
      cfg_r.yaw_coef     <= 24'sd0;
      cfg_r.thrust_upper <= 24'sd25600;
      cfg_r.thrust_lower <= -24'sd25600;
      cfg_r.angle_upper  <= 16'sd12868;
      cfg_r.angle_lower  <= -16'sd12868;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tata_pkg::CFG_SWAY_COEF:    cfg_r.sway_coef    <= cfg_data;
        tata_pkg::CFG_YAW_COEF:     cfg_r.yaw_coef     <= cfg_data;
        tata_pkg::CFG_THRUST_UPPER: cfg_r.thrust_upper <= cfg_data;
        tata_pkg::CFG_THRUST_LOWER: cfg_r.thrust_lower <= cfg_data;
        tata_pkg::CFG_ANGLE_UPPER:  cfg_r.angle_upper  <= cfg_data[tata_pkg::ANGLE_W-1:0];
        tata_pkg::CFG_ANGLE_LOWER:  cfg_r.angle_lower  <= cfg_data[tata_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/tata_ctrl.sv
module tata_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tata_pkg::dp_stat_t stat,
  output tata_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);

  localparam logic [tata_pkg::CNT_W-1:0] CORDIC_LAST = tata_pkg::CNT_W'(CORDIC_STEPS - 1);
  localparam logic [tata_pkg::CNT_W-1:0] DIV_LAST    = tata_pkg::CNT_W'(tata_pkg::DIV_W - 1);

  tata_pkg::ctrl_state_t       state_r, state_nxt;
  logic [tata_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        sel_r, sel_nxt;
  logic [1:0]                  idx_r, idx_nxt;
  logic                        pass2_r, pass2_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // State and sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tata_pkg::ST_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      idx_r       <= '0;
      pass2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      idx_r       <= idx_nxt;
      pass2_r     <= pass2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    idx_nxt       = idx_r;
    pass2_nxt     = pass2_r;
    out_valid_nxt = 1'b0;
    cmd.op        = tata_pkg::OP_NONE;
    cmd.sel       = sel_r;
    cmd.comp      = idx_r[0];
    cmd.step      = cnt_r[tata_pkg::STEP_W-1:0];
    unique case (state_r)
      tata_pkg::ST_IDLE: begin
        if (start) begin
          cmd.op    = tata_pkg::OP_LOAD;
          state_nxt = tata_pkg::ST_MUL;
        end
      end
      tata_pkg::ST_MUL: begin
        cmd.op    = tata_pkg::OP_MUL;
        state_nxt = tata_pkg::ST_SPLIT;
      end
      tata_pkg::ST_SPLIT: begin
        cmd.op    = tata_pkg::OP_SPLIT;
        sel_nxt   = 1'b0;
        pass2_nxt = 1'b0;
        state_nxt = tata_pkg::ST_POL_INIT;
      end
      tata_pkg::ST_POL_INIT: begin
        cmd.op    = tata_pkg::OP_POL_INIT;
        cnt_nxt   = '0;
        state_nxt = tata_pkg::ST_POL_ITER;
      end
      tata_pkg::ST_POL_ITER: begin
        cmd.op = tata_pkg::OP_VEC_STEP;
        if (cnt_r == CORDIC_LAST) begin
          state_nxt = tata_pkg::ST_POL_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tata_pkg::ST_POL_MUL: begin
        cmd.op    = tata_pkg::OP_POL_MUL;
        state_nxt = tata_pkg::ST_POL_DONE;
      end
      tata_pkg::ST_POL_DONE: begin
        cmd.op = tata_pkg::OP_POL_DONE;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = tata_pkg::ST_POL_INIT;
        end else begin
          state_nxt = tata_pkg::ST_CHECK;
        end
      end
      tata_pkg::ST_CHECK: begin
        if (pass2_r || !stat.sat) begin
          state_nxt = tata_pkg::ST_FINISH;
        end else begin
          sel_nxt   = 1'b0;
          state_nxt = tata_pkg::ST_FWD_INIT;
        end
      end
      tata_pkg::ST_FWD_INIT: begin
        cmd.op    = tata_pkg::OP_FWD_INIT;
        cnt_nxt   = '0;
        state_nxt = tata_pkg::ST_FWD_ITER;
      end
      tata_pkg::ST_FWD_ITER: begin
        cmd.op = tata_pkg::OP_ROT_STEP;
        if (cnt_r == CORDIC_LAST) begin
          state_nxt = tata_pkg::ST_FWD_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tata_pkg::ST_FWD_DONE: begin
        cmd.op = tata_pkg::OP_FWD_DONE;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = tata_pkg::ST_FWD_INIT;
        end else begin
          idx_nxt   = '0;
          state_nxt = tata_pkg::ST_RAT_START;
        end
      end
      tata_pkg::ST_RAT_START: begin
        cmd.sel = idx_r[1];
        // skip a force whose achievable value is zero
        if (stat.fmax_zero) begin
          if (idx_r == 2'd3) begin
            state_nxt = tata_pkg::ST_SCL_CHECK;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          cmd.op    = tata_pkg::OP_RAT_START;
          cnt_nxt   = '0;
          state_nxt = tata_pkg::ST_RAT_ITER;
        end
      end
      tata_pkg::ST_RAT_ITER: begin
        cmd.sel = idx_r[1];
        cmd.op  = tata_pkg::OP_DIV_STEP;
        if (cnt_r == DIV_LAST) begin
          state_nxt = tata_pkg::ST_RAT_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tata_pkg::ST_RAT_DONE: begin
        cmd.sel = idx_r[1];
        cmd.op  = tata_pkg::OP_RAT_DONE;
        if (idx_r == 2'd3) begin
          state_nxt = tata_pkg::ST_SCL_CHECK;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = tata_pkg::ST_RAT_START;
        end
      end
      tata_pkg::ST_SCL_CHECK: begin
        if (stat.ratio_zero) begin
          state_nxt = tata_pkg::ST_FINISH;
        end else begin
          idx_nxt   = '0;
          state_nxt = tata_pkg::ST_SCL_START;
        end
      end
      tata_pkg::ST_SCL_START: begin
        cmd.sel   = idx_r[1];
        cmd.op    = tata_pkg::OP_SCL_START;
        cnt_nxt   = '0;
        state_nxt = tata_pkg::ST_SCL_ITER;
      end
      tata_pkg::ST_SCL_ITER: begin
        cmd.sel = idx_r[1];
        cmd.op  = tata_pkg::OP_DIV_STEP;
        if (cnt_r == DIV_LAST) begin
          state_nxt = tata_pkg::ST_SCL_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tata_pkg::ST_SCL_DONE: begin
        cmd.sel = idx_r[1];
        cmd.op  = tata_pkg::OP_SCL_DONE;
        if (idx_r == 2'd3) begin
          pass2_nxt = 1'b1;
          sel_nxt   = 1'b0;
          state_nxt = tata_pkg::ST_POL_INIT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = tata_pkg::ST_SCL_START;
        end
      end
      tata_pkg::ST_FINISH: begin
        cmd.op        = tata_pkg::OP_FINISH;
        out_valid_nxt = 1'b1;
        state_nxt     = tata_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tata_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != tata_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/tata_dp.sv
module tata_dp (
  input  logic                                   clk,
  input  tata_pkg::cfg_t                         cfg,
  input  tata_pkg::dp_cmd_t                      cmd,
  input  logic signed [tata_pkg::FORCE_W-1:0]    in_surge_force,
  input  logic signed [tata_pkg::FORCE_W-1:0]    in_sway_force,
  input  logic signed [tata_pkg::FORCE_W-1:0]    in_yaw_moment,
  output tata_pkg::dp_stat_t                     stat,
  output logic signed [tata_pkg::FORCE_W-1:0]    out_port_thrust,
  output logic signed [tata_pkg::ANGLE_W-1:0]    out_port_angle,
  output logic signed [tata_pkg::FORCE_W-1:0]    out_starboard_thrust,
  output logic signed [tata_pkg::ANGLE_W-1:0]    out_starboard_angle
);

  localparam int FW = tata_pkg::FORCE_W;
  localparam int AW = tata_pkg::ANG_W;
  localparam int XW = tata_pkg::CX_W;
  localparam int ZW = tata_pkg::CZ_W;
  localparam int MW = tata_pkg::FMAX_W;
  localparam int DW = tata_pkg::DIV_W;

  // Request operands and products
  logic signed [FW-1:0] surge_r, sway_r, yaw_r;
  logic signed [47:0]   p1_r, p2_r;

  // Per-thruster state
  logic signed [FW-1:0] fx_r [2];
  logic signed [FW-1:0] fy_r [2];
  logic signed [FW-1:0] thrust_r [2];
  logic signed [AW-1:0] angle_r [2];
  logic signed [MW-1:0] fmx_r [2];
  logic signed [MW-1:0] fmy_r [2];

  // CORDIC unit
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic                 flip_r;
  logic [tata_pkg::PROD_W-1:0] prod_r;

  // Divider and ratio
  logic [DW-1:0] drem_r, dquo_r, dvs_r, ratio_r;
  logic          dneg_r;
  logic          sat_r;

  // Output registers
  logic signed [FW-1:0]               port_thrust_r, stbd_thrust_r;
  logic signed [tata_pkg::ANGLE_W-1:0] port_angle_r, stbd_angle_r;

  // Limits widened to the angle width
  logic signed [AW-1:0] ang_up, ang_lo, pos_lim, neg_lim;
  assign ang_up  = AW'(cfg.angle_upper);
  assign ang_lo  = AW'(cfg.angle_lower);
  assign pos_lim = tata_pkg::PI_Q13 + ang_lo;
  assign neg_lim = ang_up - tata_pkg::PI_Q13;

  // Selected operands
  logic signed [FW-1:0] fx_sel, fy_sel, f_cmp, thrust_sel;
  logic signed [AW-1:0] angle_sel;
  logic signed [MW-1:0] fm_cmp;
  assign fx_sel     = fx_r[cmd.sel];
  assign fy_sel     = fy_r[cmd.sel];
  assign thrust_sel = thrust_r[cmd.sel];
  assign angle_sel  = angle_r[cmd.sel];
  assign f_cmp      = cmd.comp ? fy_sel : fx_sel;
  assign fm_cmp     = cmd.comp ? fmy_r[cmd.sel] : fmx_r[cmd.sel];

  // Split demand into force pairs
  logic signed [49:0] half, ksum, s0, s1, sh0, sh1;
  logic signed [24:0] sway_p1;
  logic signed [FW-1:0] fx0_split, fx1_split, fy_split;
  always_comb begin
    half      = {{11{surge_r[FW-1]}}, surge_r, 15'b0};
    ksum      = 50'(p1_r) + 50'(p2_r);
    s0        = half + ksum + 50'sd32768;
    s1        = half - ksum + 50'sd32768;
    sh0       = s0 >>> 16;
    sh1       = s1 >>> 16;
    fx0_split = tata_pkg::sat24(sh0[47:0]);
    fx1_split = tata_pkg::sat24(sh1[47:0]);
    sway_p1   = 25'(sway_r) + 25'sd1;
    fy_split  = sway_p1[24:1];
  end

  // Pre-rotate into the right half plane
  logic signed [XW-1:0] x0, y0, xi, yi;
  logic signed [ZW-1:0] zi;
  always_comb begin
    x0 = {{4{fx_sel[FW-1]}}, fx_sel, 6'b0};
    y0 = {{4{fy_sel[FW-1]}}, fy_sel, 6'b0};
    if (x0 < 0) begin
      zi = (y0 >= 0) ? tata_pkg::PI_Q24 : -tata_pkg::PI_Q24;
      xi = -x0;
      yi = -y0;
    end else begin
      zi = '0;
      xi = x0;
      yi = y0;
    end
  end

  // One CORDIC micro-rotation
  logic signed [XW-1:0] dxv, dyv;
  logic signed [ZW-1:0] atv;
  assign dxv = cy_r >>> cmd.step;
  assign dyv = cx_r >>> cmd.step;
  assign atv = tata_pkg::atan_q24(cmd.step);

  // Magnitude, angle, reversal and thrust clamp
  logic [61:0]          tsum;
  logic signed [26:0]   t_raw, t_rev, t_cl, tu27, tl27;
  logic signed [ZW-1:0] zsum;
  logic signed [AW-1:0] a_raw, a_rev;
  logic                 clamp_hit;
  always_comb begin
    tsum  = {1'b0, prod_r} + (62'd1 << 35);
    t_raw = {1'b0, tsum[61:36]};
    zsum  = cz_r + 30'sd1024;
    a_raw = zsum[28:11];
    if (a_raw >= pos_lim) begin
      t_rev = -t_raw;
      a_rev = a_raw - tata_pkg::PI_Q13;
    end else if (a_raw <= neg_lim) begin
      t_rev = -t_raw;
      a_rev = a_raw + tata_pkg::PI_Q13;
    end else begin
      t_rev = t_raw;
      a_rev = a_raw;
    end
    tu27 = 27'(cfg.thrust_upper);
    tl27 = 27'(cfg.thrust_lower);
    clamp_hit = 1'b1;
    if (t_rev > tu27) begin
      t_cl = tu27;
    end else if (t_rev < tl27) begin
      t_cl = tl27;
    end else begin
      t_cl      = t_rev;
      clamp_hit = 1'b0;
    end
  end

  // Set up the thrust-to-force rotation
  logic signed [ZW-1:0] a0, a_fwd;
  logic                 flip_fwd;
  logic signed [54:0]   fwd_prod;
  logic signed [XW-1:0] x_fwd;
  always_comb begin
    a0 = {angle_sel[AW-1], angle_sel, 11'b0};
    if (a0 > tata_pkg::HALF_PI_Q24) begin
      a_fwd    = a0 - tata_pkg::PI_Q24;
      flip_fwd = 1'b1;
    end else if (a0 < -tata_pkg::HALF_PI_Q24) begin
      a_fwd    = a0 + tata_pkg::PI_Q24;
      flip_fwd = 1'b1;
    end else begin
      a_fwd    = a0;
      flip_fwd = 1'b0;
    end
    fwd_prod = thrust_sel * $signed({1'b0, tata_pkg::INV_GAIN_Q30});
    x_fwd    = XW'($signed(fwd_prod[53:24]));
  end

  // Round rotated forces back to Q16.8
  logic signed [XW-1:0] xr_full, yr_full;
  logic signed [MW-1:0] xr, yr;
  always_comb begin
    xr_full = (cx_r + 34'sd32) >>> 6;
    yr_full = (cy_r + 34'sd32) >>> 6;
    xr = flip_r ? -xr_full[MW-1:0] : xr_full[MW-1:0];
    yr = flip_r ? -yr_full[MW-1:0] : yr_full[MW-1:0];
  end

  // Divider operands and one restoring step
  logic [FW-1:0] abs_f;
  logic [MW-1:0] abs_fm;
  logic [DW:0]   rs, rsub;
  logic          ge;
  logic signed [FW-1:0] scl_val;
  always_comb begin
    abs_f  = f_cmp[FW-1] ? FW'(-f_cmp) : f_cmp;
    abs_fm = fm_cmp[MW-1] ? MW'(-fm_cmp) : fm_cmp;
    rs     = {drem_r, dquo_r[DW-1]};
    ge     = (rs >= {1'b0, dvs_r});
    rsub   = rs - {1'b0, dvs_r};
    if (dneg_r) begin
      scl_val = (dquo_r > 40'd8388608) ? 24'sh800000 : FW'(24'd0 - dquo_r[FW-1:0]);
    end else begin
      scl_val = (dquo_r > 40'd8388607) ? 24'sh7FFFFF : dquo_r[FW-1:0];
    end
  end

  // Deadband and angle clamp per thruster
  logic signed [FW-1:0]               t_fin [2];
  logic signed [tata_pkg::ANGLE_W-1:0] a_fin [2];
  always_comb begin
    for (int n = 0; n < 2; n++) begin
      if ((angle_r[n] > ang_up && angle_r[n] < pos_lim) ||
          (angle_r[n] < ang_lo && angle_r[n] > neg_lim)) begin
        t_fin[n] = '0;
      end else begin
        t_fin[n] = thrust_r[n];
      end
      if (angle_r[n] < ang_lo) begin
        a_fin[n] = cfg.angle_lower;
      end else if (angle_r[n] > ang_up) begin
        a_fin[n] = cfg.angle_upper;
      end else begin
        a_fin[n] = angle_r[n][tata_pkg::ANGLE_W-1:0];
      end
    end
  end

  // Execute the command
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tata_pkg::OP_NONE: ;
      tata_pkg::OP_LOAD: begin
        surge_r <= in_surge_force;
        sway_r  <= in_sway_force;
        yaw_r   <= in_yaw_moment;
      end
      tata_pkg::OP_MUL: begin
        p1_r <= cfg.sway_coef * sway_r;
        p2_r <= cfg.yaw_coef * yaw_r;
      end
      tata_pkg::OP_SPLIT: begin
        fx_r[0] <= fx0_split;
        fx_r[1] <= fx1_split;
        fy_r[0] <= fy_split;
        fy_r[1] <= fy_split;
        sat_r   <= 1'b0;
        ratio_r <= '0;
      end
      tata_pkg::OP_POL_INIT: begin
        cx_r <= xi;
        cy_r <= yi;
        cz_r <= zi;
      end
      tata_pkg::OP_VEC_STEP: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + dxv;
          cy_r <= cy_r - dyv;
          cz_r <= cz_r + atv;
        end else if (cy_r < 0) begin
          cx_r <= cx_r - dxv;
          cy_r <= cy_r + dyv;
          cz_r <= cz_r - atv;
        end
      end
      tata_pkg::OP_POL_MUL: begin
        prod_r <= cx_r[30:0] * tata_pkg::INV_GAIN_Q30;
      end
      tata_pkg::OP_POL_DONE: begin
        thrust_r[cmd.sel] <= t_cl[FW-1:0];
        angle_r[cmd.sel]  <= a_rev;
        sat_r             <= sat_r | clamp_hit;
      end
      tata_pkg::OP_FWD_INIT: begin
        cx_r   <= x_fwd;
        cy_r   <= '0;
        cz_r   <= a_fwd;
        flip_r <= flip_fwd;
      end
      tata_pkg::OP_ROT_STEP: begin
        if (cz_r >= 0) begin
          cx_r <= cx_r - dxv;
          cy_r <= cy_r + dyv;
          cz_r <= cz_r - atv;
        end else begin
          cx_r <= cx_r + dxv;
          cy_r <= cy_r - dyv;
          cz_r <= cz_r + atv;
        end
      end
      tata_pkg::OP_FWD_DONE: begin
        fmx_r[cmd.sel] <= xr;
        fmy_r[cmd.sel] <= yr;
      end
      tata_pkg::OP_RAT_START: begin
        dquo_r <= {abs_f, 16'b0};
        drem_r <= '0;
        dvs_r  <= DW'(abs_fm);
      end
      tata_pkg::OP_DIV_STEP: begin
        drem_r <= ge ? rsub[DW-1:0] : rs[DW-1:0];
        dquo_r <= {dquo_r[DW-2:0], ge};
      end
      tata_pkg::OP_RAT_DONE: begin
        if (dquo_r > ratio_r) begin
          ratio_r <= dquo_r;
        end
      end
      tata_pkg::OP_SCL_START: begin
        dquo_r <= {abs_f, 16'b0};
        drem_r <= '0;
        dvs_r  <= ratio_r;
        dneg_r <= f_cmp[FW-1];
      end
      tata_pkg::OP_SCL_DONE: begin
        if (cmd.comp) begin
          fy_r[cmd.sel] <= scl_val;
        end else begin
          fx_r[cmd.sel] <= scl_val;
        end
      end
      tata_pkg::OP_FINISH: begin
        port_thrust_r <= t_fin[0];
        port_angle_r  <= a_fin[0];
        stbd_thrust_r <= t_fin[1];
        stbd_angle_r  <= a_fin[1];
      end
      default: ;
    endcase
  end

  assign stat.sat        = sat_r;
  assign stat.fmax_zero  = (fm_cmp == '0);
  assign stat.ratio_zero = (ratio_r == '0);

  assign out_port_thrust      = port_thrust_r;
  assign out_port_angle       = port_angle_r;
  assign out_starboard_thrust = stbd_thrust_r;
  assign out_starboard_angle  = stbd_angle_r;

endmodule

// File: rtl/core/twin_azimuth_thrust_allocator.sv
// A clamp and rescale pass is carried out by the one shared CORDIC unit and the bit-serial
// 40-step divider, which is used for up to eight quotients.
// One request at a time; busy stays high until the result strobe.
// Synchronous active-low reset loads register defaults and idles the sequencer.
// The result is shown for one cycle on out_valid; the receiver cannot stall.
module twin_azimuth_thrust_allocator #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tata_pkg::FORCE_W-1:0] in_surge_force,
  input  logic signed [tata_pkg::FORCE_W-1:0] in_sway_force,
  input  logic signed [tata_pkg::FORCE_W-1:0] in_yaw_moment,
  output logic                                out_valid,
  output logic signed [tata_pkg::FORCE_W-1:0] out_port_thrust,
  output logic signed [tata_pkg::ANGLE_W-1:0] out_port_angle,
  output logic signed [tata_pkg::FORCE_W-1:0] out_starboard_thrust,
  output logic signed [tata_pkg::ANGLE_W-1:0] out_starboard_angle,
  input  logic                                cfg_we,
  input  logic [tata_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tata_pkg::FORCE_W-1:0]        cfg_data
);

  tata_pkg::cfg_t     cfg;
  tata_pkg::dp_cmd_t  cmd;
  tata_pkg::dp_stat_t stat;

  // Configuration registers
  tata_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer
  tata_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Arithmetic datapath
  tata_dp u_dp (
    .clk                  (clk),
    .cfg                  (cfg),
    .cmd                  (cmd),
    .in_surge_force       (in_surge_force),
    .in_sway_force        (in_sway_force),
    .in_yaw_moment        (in_yaw_moment),
    .stat                 (stat),
    .out_port_thrust      (out_port_thrust),
    .out_port_angle       (out_port_angle),
    .out_starboard_thrust (out_starboard_thrust),
    .out_starboard_angle  (out_starboard_angle)
  );

`ifndef SYNTHESIS
  // An accepted request keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A result appears only once the sequencer is back to idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // A result strobe follows a busy cycle
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in flight");

  // The strobe lasts one cycle
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
`endif

endmodule
